FILE: design/skc_pkg.sv
// ----------------------------------------------------------------------------
// Shared key cache package
// Request and response types, codes and constants for the shared key cache.
// ----------------------------------------------------------------------------
package skc_pkg;

    localparam int WAYS_DEFAULT  = 4;
    localparam int SETS          = 256;
    localparam int SET_BITS      = 8;
    localparam int SET_SEL_LSB   = 48;
    localparam int KEY_BITS      = 256;
    localparam int META_BITS     = 64;
    localparam int Q_DEPTH       = 2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd600;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [63:0] pubkey_w0;
        logic [63:0] pubkey_w1;
        logic [63:0] pubkey_w2;
        logic [63:0] pubkey_w3;
        logic [63:0] fill_w0;
        logic [63:0] fill_w1;
        logic [63:0] fill_w2;
        logic [63:0] fill_w3;
        logic [31:0] now_seconds;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [1:0]  way_used;
        logic [63:0] key_out_w0;
        logic [63:0] key_out_w1;
        logic [63:0] key_out_w2;
        logic [63:0] key_out_w3;
    } rsp_t;

endpackage

FILE: design/skc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module skc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/skc_front.sv
// ----------------------------------------------------------------------------
// Shared key cache front end
// Accepts requests and holds them in a short queue for the lookup engine.
// ----------------------------------------------------------------------------
module skc_front
    import skc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  req_t req,
    output logic q_valid,
    output req_t q_data,
    input  logic q_pop
);

    req_t       slot_reg [Q_DEPTH];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (cnt_reg == 2'(Q_DEPTH));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = slot_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        wptr_next = do_push ? ~wptr_reg : wptr_reg;
        rptr_next = do_pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

FILE: design/skc_back.sv
// ----------------------------------------------------------------------------
// Shared key cache back end
// Reads a set, compares tags, picks a victim and writes on insert or hit.
// ----------------------------------------------------------------------------
module skc_back
    import skc_pkg::*;
#(
    parameter int WAYS = WAYS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] timeout,
    input  logic        q_valid,
    input  req_t        q_data,
    output logic        q_pop,
    input  logic        rsp_full,
    output logic        rsp_push,
    output rsp_t        rsp_data
);

    localparam int WIDX = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    logic [1:0]          state_reg, state_next;
    req_t                cur_reg;
    logic [SETS-1:0]     row_init_reg;
    logic                rowv_reg;
    logic [WAYS-1:0]     match_reg;
    logic [WAYS-1:0]     free_reg;
    logic [31:0]         count_reg [WAYS];

    logic [SET_BITS-1:0] set_idx;
    logic [KEY_BITS-1:0] pk;
    logic [KEY_BITS-1:0] fill;
    logic                rd_en;
    logic                wr_en;
    logic [WAYS-1:0]     vram_rdata;
    logic [WAYS-1:0]     vcur;
    logic [KEY_BITS-1:0] tag_rdata [WAYS];
    logic [KEY_BITS-1:0] sec_rdata [WAYS];
    logic [META_BITS-1:0] meta_rdata [WAYS];

    logic                hit_any;
    logic [WIDX-1:0]     hit_way;
    logic                found_free;
    logic [WIDX-1:0]     victim;
    logic [31:0]         best;
    logic                have_best;
    logic [WIDX-1:0]     sel_way;
    logic                is_ins;
    logic [31:0]         new_count;
    logic [KEY_BITS-1:0] hit_key;

    assign set_idx = cur_reg.pubkey_w3[SET_SEL_LSB +: SET_BITS];
    assign pk      = {cur_reg.pubkey_w3, cur_reg.pubkey_w2, cur_reg.pubkey_w1, cur_reg.pubkey_w0};
    assign fill    = {cur_reg.fill_w3, cur_reg.fill_w2, cur_reg.fill_w1, cur_reg.fill_w0};
    assign is_ins  = (cur_reg.cmd == CMD_INSERT);
    assign rd_en   = (state_reg == ST_READ);
    assign wr_en   = (state_reg == ST_WRITE) && !rsp_full;
    assign q_pop   = (state_reg == ST_IDLE) && q_valid;
    assign vcur    = rowv_reg ? vram_rdata : '0;

    skc_ram #(.WIDTH(WAYS), .DEPTH(SETS)) u_valid_ram (
        .clk   (clk),
        .we    (wr_en && is_ins),
        .waddr (set_idx),
        .wdata (vcur | (WAYS'(1) << sel_way)),
        .re    (rd_en),
        .raddr (set_idx),
        .rdata (vram_rdata)
    );

    for (genvar g = 0; g < WAYS; g++)
    begin : g_way
        logic sel_g;
        assign sel_g = (sel_way == WIDX'(g));

        skc_ram #(.WIDTH(KEY_BITS), .DEPTH(SETS)) u_tag_ram (
            .clk   (clk),
            .we    (wr_en && is_ins && sel_g),
            .waddr (set_idx),
            .wdata (pk),
            .re    (rd_en),
            .raddr (set_idx),
            .rdata (tag_rdata[g])
        );

        skc_ram #(.WIDTH(KEY_BITS), .DEPTH(SETS)) u_sec_ram (
            .clk   (clk),
            .we    (wr_en && is_ins && sel_g),
            .waddr (set_idx),
            .wdata (fill),
            .re    (rd_en),
            .raddr (set_idx),
            .rdata (sec_rdata[g])
        );

        skc_ram #(.WIDTH(META_BITS), .DEPTH(SETS)) u_meta_ram (
            .clk   (clk),
            .we    (wr_en && (is_ins || hit_any) && sel_g),
            .waddr (set_idx),
            .wdata ({new_count, cur_reg.now_seconds}),
            .re    (rd_en),
            .raddr (set_idx),
            .rdata (meta_rdata[g])
        );
    end

    always_comb
    begin
        hit_any    = 1'b0;
        hit_way    = '0;
        found_free = 1'b0;
        victim     = '0;
        best       = '0;
        have_best  = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (match_reg[w] && !hit_any)
            begin
                hit_any = 1'b1;
                hit_way = WIDX'(w);
            end
            if (!found_free)
            begin
                if (free_reg[w])
                begin
                    found_free = 1'b1;
                    victim     = WIDX'(w);
                end
                else if (!have_best || count_reg[w] < best)
                begin
                    best      = count_reg[w];
                    victim    = WIDX'(w);
                    have_best = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        sel_way   = is_ins ? victim : hit_way;
        new_count = is_ins ? 32'd1 :
                    (count_reg[hit_way] + 32'((&count_reg[hit_way]) ? 1'b0 : 1'b1));
        hit_key   = sec_rdata[hit_way];
        rsp_data  = '0;
        rsp_data.way_used = 2'(sel_way);
        if (!is_ins)
        begin
            rsp_data.hit = hit_any;
            if (hit_any)
            begin
                rsp_data.key_out_w0 = hit_key[63:0];
                rsp_data.key_out_w1 = hit_key[127:64];
                rsp_data.key_out_w2 = hit_key[191:128];
                rsp_data.key_out_w3 = hit_key[255:192];
            end
            else
            begin
                rsp_data.way_used = 2'd0;
            end
        end
    end

    assign rsp_push = wr_en;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (q_valid) state_next = ST_READ;
            ST_READ:  state_next = ST_CMP;
            ST_CMP:   state_next = ST_WRITE;
            ST_WRITE: if (!rsp_full) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
        if (rd_en)
        begin
            rowv_reg <= row_init_reg[set_idx];
        end
        if (state_reg == ST_CMP)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                match_reg[w] <= vcur[w] && (tag_rdata[w] == pk);
                free_reg[w]  <= !vcur[w] ||
                    (({1'b0, meta_rdata[w][31:0]} + {17'd0, timeout}) <=
                     {1'b0, cur_reg.now_seconds});
                count_reg[w] <= meta_rdata[w][63:32];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            row_init_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en && is_ins)
            begin
                row_init_reg[set_idx] <= 1'b1;
            end
        end
    end

endmodule

FILE: design/shared_key_cache_lfu_timeout.sv
// ----------------------------------------------------------------------------
// Shared key cache with LFU and timeout replacement
// Top level: front queue, lookup engine, response register, timeout register.
// ----------------------------------------------------------------------------
// Each request passes through four engine steps (dequeue, set read, compare,
// write back and response); write back waits while the response register is
// full. The engine serves one request at a time, set by the registered set
// read and the compare stage ahead of the write-back of counts and stamps. Two
// requests can wait in the input queue and one response in the output
// register. No clearing pass after reset: per-set flags mark unwritten sets.
module shared_key_cache_lfu_timeout
    import skc_pkg::*;
#(
    parameter int WAYS = WAYS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  req_t        req,
    output logic        empty,
    input  logic        pop,
    output rsp_t        rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic        q_valid;
    req_t        q_data;
    logic        q_pop;
    logic        rsp_push;
    rsp_t        rsp_data;
    logic [15:0] timeout_reg;
    logic        rsp_valid_reg;
    rsp_t        rsp_reg;

    skc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .req     (req),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    skc_back #(.WAYS(WAYS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .timeout  (timeout_reg),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .rsp_full (rsp_valid_reg),
        .rsp_push (rsp_push),
        .rsp_data (rsp_data)
    );

    assign cfg_ready = 1'b1;
    assign empty     = !rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (rsp_push)
        begin
            rsp_reg <= rsp_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                timeout_reg <= cfg_data;
            end
            if (rsp_push)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: design/skc_checker.sv
// ----------------------------------------------------------------------------
// Shared key cache checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module skc_checker
    import skc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input req_t        req,
    input logic        empty,
    input logic        pop,
    input rsp_t        rsp,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [15:0] cfg_data
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("response pending during reset");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(rsp)))
        else $error("response changed before pop");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !rsp.hit) |-> (rsp.key_out_w0 == 64'd0 && rsp.key_out_w1 == 64'd0
            && rsp.key_out_w2 == 64'd0 && rsp.key_out_w3 == 64'd0))
        else $error("key data on a non-hit response");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port stalled");

endmodule

bind shared_key_cache_lfu_timeout skc_checker u_skc_checker (.*);
